// ===== hdl/wgm_pkg.sv =====
// Package for the watercolor granulation mask block: payload structs, configuration
// layout, hash and blend constants, and the octave reciprocal table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  localparam logic [31:0] MIX_K1        = 32'h7feb352d;
  localparam logic [31:0] MIX_K2        = 32'h846ca68b;
  localparam logic [31:0] HASH_GOLD     = 32'h9e3779b9;
  localparam logic [31:0] OCT_SEED_STEP = 32'd1013;
  localparam logic [31:0] OFF_SALT_X    = 32'hA1B2C3D4;
  localparam logic [31:0] OFF_SALT_Y    = 32'h31415926;

  localparam logic [16:0] UNITY_Q16       = 17'd65536;
  localparam logic [15:0] HALF_Q15        = 16'd32768;
  localparam logic [16:0] EASE_THREE_HALF = 17'd98304;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned REG_ADDR_W = 5;

  // Index 0 and 1 unused: one octave needs no scaling.
  localparam logic [31:0] RECIP_TABLE [0:16] = '{
    32'd0,          32'd0,          32'd1431655765, 32'd613566757,
    32'd286331153,  32'd138547332,  32'd68174084,   32'd33818640,
    32'd16843009,   32'd8405024,    32'd4198404,    32'd2098177,
    32'd1048832,    32'd524352,     32'd262160,     32'd131076,
    32'd65537
  };

  typedef enum logic [2:0] {
    REG_NOISE_SEED    = 3'd0,
    REG_OCTAVE_COUNT  = 3'd1,
    REG_LATTICE_SCALE = 3'd2,
    REG_GRANULATION   = 3'd3,
    REG_STRENGTH      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  mask_coverage;
    logic [7:0]  channel_zero;
    logic [7:0]  channel_one;
    logic [7:0]  channel_two;
    logic [7:0]  channel_three;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_channel_zero;
    logic [7:0] out_channel_one;
    logic [7:0] out_channel_two;
    logic [7:0] out_channel_three;
    logic [7:0] final_coverage;
  } pixel_out_t;

  typedef struct packed {
    logic [31:0] noise_seed;
    logic [3:0]  octave_count;
    logic [31:0] lattice_scale;
    logic [16:0] granulation;
    logic [15:0] strength;
  } cfg_t;

  typedef struct packed {
    logic       outside;
    logic [7:0] mask;
    logic [7:0] channel_zero;
    logic [7:0] channel_one;
    logic [7:0] channel_two;
    logic [7:0] channel_three;
  } side_t;

  typedef struct packed {
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    side_t       side;
  } front_item_t;

  typedef struct packed {
    logic        push;
    front_item_t item;
  } fifo_wr_t;

  typedef struct packed {
    logic        empty;
    front_item_t item;
  } fifo_rd_t;

  function automatic logic [31:0] mix_shift16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [31:0] mix_shift15(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  function automatic logic [31:0] hash_pre(input logic [15:0] c, input logic [31:0] h);
    return {16'h0000, c} + HASH_GOLD + (h << 6) + (h >> 2);
  endfunction

  function automatic logic [15:0] blend_q15(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] w);
    logic [15:0] wc;
    logic [32:0] s;
    wc = HALF_Q15 - w;
    s  = 33'(a) * 33'(wc) + 33'(b) * 33'(w);
    return s[30:15];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/watercolor_granulation_mask.sv =====
// Watercolor granulation mask top level: configuration registers, front end,
// queue and noise back end. Depends on wgm_pkg and all wgm_* modules.
// Throughput: one pixel per cycle unless in_stall_o holds the input; every octave has its own hash lane.
// Path from input acceptance to output valid with an empty queue: 4 front stages from
// the accepting edge, the queue, 15 back stages and the output register.
// Reset: asynchronous active low; clears pipeline valids and queue, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module watercolor_granulation_mask import wgm_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = 8,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pixel_in_t             in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pixel_out_t                 out_data_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     fifo_full;
  logic     pop;
  fifo_wr_t fifo_wr;
  fifo_rd_t fifo_rd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[REG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_seed    <= 32'd1337;
      cfg_q.octave_count  <= 4'd2;
      cfg_q.lattice_scale <= 32'd335544;
      cfg_q.granulation   <= 17'd11796;
      cfg_q.strength      <= 16'd4096;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NOISE_SEED:    cfg_q.noise_seed    <= pwdata;
        REG_OCTAVE_COUNT:  cfg_q.octave_count  <= pwdata[3:0];
        REG_LATTICE_SCALE: cfg_q.lattice_scale <= pwdata;
        REG_GRANULATION:   cfg_q.granulation   <= pwdata[16:0];
        REG_STRENGTH:      cfg_q.strength      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NOISE_SEED:    prdata = cfg_q.noise_seed;
      REG_OCTAVE_COUNT:  prdata = 32'(cfg_q.octave_count);
      REG_LATTICE_SCALE: prdata = cfg_q.lattice_scale;
      REG_GRANULATION:   prdata = 32'(cfg_q.granulation);
      REG_STRENGTH:      prdata = 32'(cfg_q.strength);
      default:           prdata = 32'd0;
    endcase
  end

  wgm_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (fifo_full),
    .wr_o       (fifo_wr)
  );

  wgm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fifo_wr),
    .full_o (fifo_full),
    .pop_i  (pop),
    .rd_o   (fifo_rd)
  );

  wgm_back #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rd_i        (fifo_rd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_zero_cov_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.final_coverage == 8'd0) |->
      (out_data_o.out_channel_zero == 8'd0 && out_data_o.out_channel_one == 8'd0 &&
       out_data_o.out_channel_two == 8'd0 && out_data_o.out_channel_three == 8'd0))
    else $error("channels nonzero with zero coverage");

  a_chan_below_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.out_channel_zero <= out_data_o.final_coverage &&
       out_data_o.out_channel_one <= out_data_o.final_coverage &&
       out_data_o.out_channel_two <= out_data_o.final_coverage &&
       out_data_o.out_channel_three <= out_data_o.final_coverage))
    else $error("scaled channel exceeds coverage");

  a_fifo_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !fifo_wr.push)
    else $error("queue push while full");
`endif

endmodule

`default_nettype wire

// ===== hdl/wgm_front.sv =====
// Front end: accepts pixels, classifies outside pixels, adds the seed offset and
// scales the position to lattice coordinates. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_front import wgm_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pixel_in_t in_data_i,
  input  wire logic      full_i,
  output fifo_wr_t       wr_o
);

  localparam int unsigned POS_W  = COORD_BITS + 17;
  localparam int unsigned PROD_W = POS_W + 16;
  localparam int unsigned SUM_W  = POS_W + 32;

  logic              en;
  logic [3:0]        valid_q;
  side_t             side1_q, side2_q, side3_q, side4_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [PROD_W-1:0] plo_x_q, phi_x_q, plo_y_q, phi_y_q;
  logic [31:0]       cx_q, cy_q;
  logic [31:0]       off_x_q, off_y_q;
  logic [31:0]       ox_m, oy_m, ox_h, oy_h;
  logic [23:0]       off_x, off_y;
  logic [15:0]       px_wide, py_wide;
  logic [SUM_W-1:0]  sum_x, sum_y;
  side_t             side_in;

  assign en         = !(valid_q[3] && full_i);
  assign in_stall_o = !en;

  assign px_wide = 16'(in_data_i.pixel_x);
  assign py_wide = 16'(in_data_i.pixel_y);

  always_comb begin
    side_in.outside       = (in_data_i.mask_coverage == 8'd0);
    side_in.mask          = in_data_i.mask_coverage;
    side_in.channel_zero  = in_data_i.channel_zero;
    side_in.channel_one   = in_data_i.channel_one;
    side_in.channel_two   = in_data_i.channel_two;
    side_in.channel_three = in_data_i.channel_three;
  end

  always_ff @(posedge clk_i) begin
    off_x_q <= mix_shift16(cfg_i.noise_seed ^ OFF_SALT_X) * MIX_K1;
    off_y_q <= mix_shift16(cfg_i.noise_seed ^ OFF_SALT_Y) * MIX_K1;
  end

  assign ox_m  = mix_shift15(off_x_q) * MIX_K2;
  assign oy_m  = mix_shift15(off_y_q) * MIX_K2;
  assign ox_h  = mix_shift16(ox_m);
  assign oy_h  = mix_shift16(oy_m);
  assign off_x = {ox_h[9:0], 14'h0000};
  assign off_y = {oy_h[9:0], 14'h0000};

  assign sum_x = (SUM_W'(phi_x_q) << 16) + SUM_W'(plo_x_q);
  assign sum_y = (SUM_W'(phi_y_q) << 16) + SUM_W'(plo_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 4'b0000;
    end else if (en) begin
      valid_q <= {valid_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= px_wide[COORD_BITS-1:0];
      py_q    <= py_wide[COORD_BITS-1:0];
      side1_q <= side_in;
      pos_x_q <= POS_W'({px_q, 16'h0000}) + POS_W'(off_x);
      pos_y_q <= POS_W'({py_q, 16'h0000}) + POS_W'(off_y);
      side2_q <= side1_q;
      plo_x_q <= PROD_W'(pos_x_q) * PROD_W'(cfg_i.lattice_scale[15:0]);
      phi_x_q <= PROD_W'(pos_x_q) * PROD_W'(cfg_i.lattice_scale[31:16]);
      plo_y_q <= PROD_W'(pos_y_q) * PROD_W'(cfg_i.lattice_scale[15:0]);
      phi_y_q <= PROD_W'(pos_y_q) * PROD_W'(cfg_i.lattice_scale[31:16]);
      side3_q <= side2_q;
      cx_q    <= sum_x[55:24];
      cy_q    <= sum_y[55:24];
      side4_q <= side3_q;
    end
  end

  always_comb begin
    wr_o.push         = valid_q[3] && !full_i;
    wr_o.item.coord_x = cx_q;
    wr_o.item.coord_y = cy_q;
    wr_o.item.side    = side4_q;
  end

endmodule

`default_nettype wire

// ===== hdl/wgm_fifo.sv =====
// Short queue between the front end and the noise back end.
// Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_fifo import wgm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fifo_wr_t wr_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output fifo_rd_t      rd_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  front_item_t      mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign full_o     = (count_q == CNT_W'(FIFO_DEPTH));
  assign rd_o.empty = (count_q == '0);
  assign rd_o.item  = mem_q[rd_ptr_q];
  assign push       = wr_i.push && !full_o;
  assign pop        = pop_i && !rd_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wgm_octave.sv =====
// One noise octave: four hashed lattice corners, smoothstep weights and
// bilinear blend, nine stages deep. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_octave import wgm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] cx_i,
  input  wire logic [31:0] cy_i,
  input  wire logic [31:0] seed_i,
  output logic [15:0]      noise_o
);

  localparam int unsigned EU_DLY = 6;
  localparam int unsigned EV_DLY = 7;

  logic [15:0] x_c [2];
  logic [15:0] y_c [2];
  logic [14:0] tu, tv;
  logic [29:0] sq_u, sq_v;
  logic [31:0] ez_u, ez_v;
  logic [31:0] h1_c [2];
  logic [31:0] h2_c [4];
  logic [31:0] hz_c [4];

  logic [31:0] mx1_q [2];
  logic [31:0] mx2_q [2];
  logic [15:0] y1_q [2];
  logic [15:0] y2_q [2];
  logic [31:0] seed1_q, seed2_q;
  logic [14:0] tu1_q, tv1_q, t2u_q, t2v_q;
  logic [15:0] eu_q [EU_DLY];
  logic [15:0] ev_q [EV_DLY];
  logic [31:0] my1_q [4];
  logic [31:0] my2_q [4];
  logic [31:0] h1a_q [4];
  logic [31:0] h1b_q [4];
  logic [31:0] mz1_q [4];
  logic [31:0] mz2_q [4];
  logic [15:0] corner_q [4];
  logic [15:0] top_q, bot_q, noise_q;

  assign x_c[0] = cx_i[31:16];
  assign x_c[1] = cx_i[31:16] + 16'd1;
  assign y_c[0] = cy_i[31:16];
  assign y_c[1] = cy_i[31:16] + 16'd1;
  assign tu     = cx_i[15:1];
  assign tv     = cy_i[15:1];

  assign sq_u = 30'(tu) * 30'(tu);
  assign sq_v = 30'(tv) * 30'(tv);
  assign ez_u = 32'(t2u_q) * 32'(EASE_THREE_HALF - {1'b0, tu1_q, 1'b0});
  assign ez_v = 32'(t2v_q) * 32'(EASE_THREE_HALF - {1'b0, tv1_q, 1'b0});

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      h1_c[k] = seed2_q ^ mix_shift16(mx2_q[k]);
    end
    for (int c = 0; c < 4; c++) begin
      h2_c[c] = h1b_q[c] ^ mix_shift16(my2_q[c]);
      hz_c[c] = mix_shift16(mz2_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        mx1_q[k] <= mix_shift16(hash_pre(x_c[k], seed_i)) * MIX_K1;
        mx2_q[k] <= mix_shift15(mx1_q[k]) * MIX_K2;
        y1_q[k]  <= y_c[k];
        y2_q[k]  <= y1_q[k];
      end
      seed1_q <= seed_i;
      seed2_q <= seed1_q;
      tu1_q   <= tu;
      tv1_q   <= tv;
      t2u_q   <= sq_u[29:15];
      t2v_q   <= sq_v[29:15];
      eu_q[0] <= ez_u[30:15];
      ev_q[0] <= ez_v[30:15];
      for (int d = 1; d < EU_DLY; d++) begin
        eu_q[d] <= eu_q[d-1];
      end
      for (int d = 1; d < EV_DLY; d++) begin
        ev_q[d] <= ev_q[d-1];
      end
      for (int c = 0; c < 4; c++) begin
        my1_q[c]    <= mix_shift16(hash_pre(y2_q[c >> 1], h1_c[c & 1])) * MIX_K1;
        h1a_q[c]    <= h1_c[c & 1];
        my2_q[c]    <= mix_shift15(my1_q[c]) * MIX_K2;
        h1b_q[c]    <= h1a_q[c];
        mz1_q[c]    <= mix_shift16(h2_c[c]) * MIX_K1;
        mz2_q[c]    <= mix_shift15(mz1_q[c]) * MIX_K2;
        corner_q[c] <= hz_c[c][31:16];
      end
      top_q   <= blend_q15(corner_q[0], corner_q[1], eu_q[EU_DLY-1]);
      bot_q   <= blend_q15(corner_q[2], corner_q[3], eu_q[EU_DLY-1]);
      noise_q <= blend_q15(top_q, bot_q, ev_q[EV_DLY-1]);
    end
  end

  assign noise_o = noise_q;

endmodule

`default_nettype wire

// ===== hdl/wgm_back.sv =====
// Back end: per-octave noise lanes, octave sum and normalization, granulation,
// strength and channel scaling, with the output register. Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_back import wgm_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire fifo_rd_t rd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pixel_out_t    out_data_o
);

  localparam int unsigned NSTAGE = 15;
  localparam int unsigned ACC_W  = 16 + MAX_OCTAVES;
  localparam int unsigned MUL_W  = ACC_W + 32;
  localparam int unsigned KW     = $clog2(MAX_OCTAVES + 1);

  logic              en;
  logic [NSTAGE-1:0] valid_q;
  side_t             side_q [NSTAGE];
  logic [31:0]       cx0_q, cy0_q;
  logic [15:0]       noise_w [MAX_OCTAVES];
  logic [ACC_W-1:0]  acc_sum, acc_q, acc_n;
  logic [15:0]       paper, paper_q;
  logic [16:0]       gs, factor_q;
  logic [32:0]       fsum;
  logic [24:0]       mf_q;
  logic [40:0]       cv;
  logic [7:0]        cov, cov_q;
  logic [4:0]        oct5, kc5;
  logic [KW-1:0]     k;
  logic [MUL_W-1:0]  prod;
  logic [ACC_W-1:0]  pfull;
  logic              out_valid_q;
  pixel_out_t        out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign pop_o       = en && !rd_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    oct5 = {1'b0, cfg_i.octave_count};
    if (oct5 == 5'd0) begin
      kc5 = 5'd1;
    end else if (oct5 > 5'(MAX_OCTAVES)) begin
      kc5 = 5'(MAX_OCTAVES);
    end else begin
      kc5 = oct5;
    end
    k = KW'(kc5);
  end

  for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_oct
    logic [31:0] seed_oct;
    assign seed_oct = cfg_i.noise_seed + 32'(gi) * OCT_SEED_STEP;
    wgm_octave u_octave (
      .clk_i   (clk_i),
      .en_i    (en),
      .cx_i    (cx0_q << gi),
      .cy_i    (cy0_q << gi),
      .seed_i  (seed_oct),
      .noise_o (noise_w[gi])
    );
  end

  always_comb begin
    acc_sum = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (i < int'(k)) begin
        acc_sum = acc_sum + (ACC_W'(noise_w[i]) << (MAX_OCTAVES - 1 - i));
      end
    end
  end

  always_comb begin
    acc_n = acc_q >> (KW'(MAX_OCTAVES) - k);
    prod  = MUL_W'(acc_n) * MUL_W'(RECIP_TABLE[kc5]) + (MUL_W'(1) << 31);
    pfull = (k == KW'(1)) ? acc_n : prod[MUL_W-1:32];
    paper = (pfull > ACC_W'(16'hFFFF)) ? 16'hFFFF : pfull[15:0];
  end

  always_comb begin
    gs   = (cfg_i.granulation > UNITY_Q16) ? UNITY_Q16 : cfg_i.granulation;
    fsum = {UNITY_Q16 - gs, 16'h0000} + 33'(gs) * 33'(paper_q);
    cv   = 41'(mf_q) * 41'(cfg_i.strength) + (41'(1) << 27);
    if (side_q[13].outside) begin
      cov = 8'd0;
    end else if (cv[40:28] > 13'd255) begin
      cov = 8'd255;
    end else begin
      cov = cv[35:28];
    end
  end

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] f);
    logic [15:0] o;
    logic [16:0] q;
    o = 16'(c) * 16'(f) + 16'd127;
    q = 17'(o) + 17'(o[15:8]) + 17'd1;
    return q[15:8];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[NSTAGE-2:0], pop_o};
      out_valid_q <= valid_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= rd_i.item.side;
      cx0_q     <= rd_i.item.coord_x;
      cy0_q     <= rd_i.item.coord_y;
      for (int s = 1; s < NSTAGE; s++) begin
        side_q[s] <= side_q[s-1];
      end
      acc_q    <= acc_sum;
      paper_q  <= paper;
      factor_q <= fsum[32:16];
      mf_q     <= 25'(side_q[12].mask) * 25'(factor_q);
      cov_q    <= cov;
      out_q.out_channel_zero  <= scale_chan(side_q[14].channel_zero, cov_q);
      out_q.out_channel_one   <= scale_chan(side_q[14].channel_one, cov_q);
      out_q.out_channel_two   <= scale_chan(side_q[14].channel_two, cov_q);
      out_q.out_channel_three <= scale_chan(side_q[14].channel_three, cov_q);
      out_q.final_coverage    <= cov_q;
    end
  end

endmodule

`default_nettype wire
